### rtl/core/rts_pkg.sv
`timescale 1ns / 1ps

package rts_pkg;

    // Request and report codes carried in the action field
    localparam logic [2:0] ACT_PROBE = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_READ  = 3'd2;
    localparam logic [2:0] ACT_DONE  = 3'd3;
    localparam logic [2:0] ACT_BYTE  = 3'd4;

    // Bus primitives
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_SEND  = 3'd2;
    localparam logic [2:0] OP_RECV  = 3'd3;
    localparam logic [2:0] OP_ACK   = 3'd4;
    localparam logic [2:0] OP_STOP  = 3'd5;

    // Request kinds
    localparam logic [1:0] KIND_PROBE = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Sequencer phases
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ADDR   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_REG    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_WANT   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_DATA   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_RSTOP  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RSTART = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RADDR  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RECV   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_ACK    = 4'd10;
    localparam logic [PHASE_W-1:0] PH_STOP   = 4'd11;

    localparam logic [7:0] READ_BIT = 8'h01;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] dev_address;
        logic [7:0] reg_address;
        logic [7:0] byte_count;
        logic       target_nack;
        logic [7:0] rx_data;
        logic [7:0] write_byte;
    } req_word_t;

    typedef struct packed {
        logic [2:0] bus_op;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic [7:0] read_data;
        logic       read_valid;
        logic       want_byte;
        logic       finished;
        logic       succeeded;
        logic       refused;
    } rsp_word_t;

endpackage

### rtl/core/rts_if.sv
`timescale 1ns / 1ps

interface rts_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] dev_address;
    logic [7:0] reg_address;
    logic [7:0] byte_count;
    logic       target_nack;
    logic [7:0] rx_data;
    logic [7:0] write_byte;

    modport source (
        output valid, action, dev_address, reg_address, byte_count,
               target_nack, rx_data, write_byte,
        input  ready
    );
    modport sink (
        input  valid, action, dev_address, reg_address, byte_count,
               target_nack, rx_data, write_byte,
        output ready
    );
endinterface

interface rts_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_op;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic [7:0] read_data;
    logic       read_valid;
    logic       want_byte;
    logic       finished;
    logic       succeeded;
    logic       refused;

    modport source (
        output valid, bus_op, tx_byte, ack_level, read_data, read_valid,
               want_byte, finished, succeeded, refused,
        input  ready
    );
    modport sink (
        input  valid, bus_op, tx_byte, ack_level, read_data, read_valid,
               want_byte, finished, succeeded, refused,
        output ready
    );
endinterface

### rtl/core/rts_seq_core.sv
`timescale 1ns / 1ps

module rts_seq_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_en,
    input  rts_pkg::req_word_t           item,
    output rts_pkg::rsp_word_t           result,
    output logic [rts_pkg::PHASE_W-1:0]  phase
);
    import rts_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]         kind_reg, kind_next;
    logic [7:0]         target_reg, target_next;
    logic [7:0]         index_reg, index_next;
    logic [7:0]         left_reg, left_next;
    logic               failed_reg, failed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            kind_reg   <= KIND_PROBE;
            target_reg <= '0;
            index_reg  <= '0;
            left_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            target_reg <= target_next;
            index_reg  <= index_next;
            left_reg   <= left_next;
            failed_reg <= failed_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        target_next = target_reg;
        index_next  = index_reg;
        left_next   = left_reg;
        failed_next = failed_reg;
        result      = '0;

        if (item.action == ACT_PROBE || item.action == ACT_WRITE ||
            item.action == ACT_READ)
        begin
            if (phase_reg != PH_IDLE)
            begin
                result.refused = 1'b1;
            end
            else
            begin
                kind_next     = item.action[1:0];
                target_next   = item.dev_address;
                index_next    = item.reg_address;
                left_next     = item.byte_count;
                failed_next   = 1'b0;
                result.bus_op = OP_START;
                phase_next    = PH_START;
            end
        end
        else if (item.action == ACT_DONE)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    result.bus_op  = OP_SEND;
                    result.tx_byte = target_reg;
                    phase_next     = PH_ADDR;
                end
                PH_ADDR:
                begin
                    if (item.target_nack)
                    begin
                        failed_next   = 1'b1;
                        result.bus_op = OP_STOP;
                        phase_next    = PH_STOP;
                    end
                    else if (kind_reg == KIND_PROBE)
                    begin
                        result.bus_op = OP_STOP;
                        phase_next    = PH_STOP;
                    end
                    else
                    begin
                        result.bus_op  = OP_SEND;
                        result.tx_byte = index_reg;
                        phase_next     = PH_REG;
                    end
                end
                PH_REG, PH_DATA:
                begin
                    if (item.target_nack)
                    begin
                        failed_next   = 1'b1;
                        result.bus_op = OP_STOP;
                        phase_next    = PH_STOP;
                    end
                    else if (phase_reg == PH_REG && kind_reg == KIND_READ)
                    begin
                        result.bus_op = OP_STOP;
                        phase_next    = PH_RSTOP;
                    end
                    else if (left_reg != 8'd0)
                    begin
                        result.want_byte = 1'b1;
                        phase_next       = PH_WANT;
                    end
                    else
                    begin
                        result.bus_op = OP_STOP;
                        phase_next    = PH_STOP;
                    end
                end
                PH_RSTOP:
                begin
                    result.bus_op = OP_START;
                    phase_next    = PH_RSTART;
                end
                PH_RSTART:
                begin
                    result.bus_op  = OP_SEND;
                    result.tx_byte = target_reg | READ_BIT;
                    phase_next     = PH_RADDR;
                end
                PH_RADDR:
                begin
                    if (item.target_nack)
                    begin
                        failed_next   = 1'b1;
                        result.bus_op = OP_STOP;
                        phase_next    = PH_STOP;
                    end
                    else
                    begin
                        result.bus_op = OP_RECV;
                        phase_next    = PH_RECV;
                    end
                end
                PH_RECV:
                begin
                    result.bus_op     = OP_ACK;
                    result.ack_level  = (left_reg == 8'd1);
                    result.read_data  = item.rx_data;
                    result.read_valid = 1'b1;
                    left_next         = (left_reg > 8'd1) ? left_reg - 8'd1 : 8'd0;
                    phase_next        = PH_ACK;
                end
                PH_ACK:
                begin
                    if (left_reg != 8'd0)
                    begin
                        result.bus_op = OP_RECV;
                        phase_next    = PH_RECV;
                    end
                    else
                    begin
                        result.bus_op = OP_STOP;
                        phase_next    = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    result.finished  = 1'b1;
                    result.succeeded = !failed_reg;
                    phase_next       = PH_IDLE;
                end
                default:
                begin
                    result.refused = 1'b1;
                end
            endcase
        end
        else if (item.action == ACT_BYTE && phase_reg == PH_WANT)
        begin
            result.bus_op  = OP_SEND;
            result.tx_byte = item.write_byte;
            left_next      = left_reg - 8'd1;
            phase_next     = PH_DATA;
        end
        else
        begin
            result.refused = 1'b1;
        end
    end

    assign phase = phase_reg;

endmodule

### rtl/core/i2c_register_transaction_sequencer.sv
`timescale 1ns / 1ps

// I2C register transaction sequencer. Send a probe, register-write or
// register-read request on req and take the bus primitives it breaks into
// (start, address byte, register byte, data, stop) from rsp, one word each;
// report every finished primitive back on req as "primitive done" with the
// target's ack bit and any received byte, and supply write data as "write
// byte" words when a rsp word asks for one. Every req word yields exactly one
// rsp word, including refusals of words that arrive when not expected. The
// block takes one word per clock while rsp is not stalled: a word lands in the
// input register, the sequencer state advances and the result is captured in
// the output register, from which it shows on rsp. While rsp is stalled the
// block holds one word in each register before it drops req.ready; once both
// are full, req.ready follows rsp.ready combinationally.

module i2c_register_transaction_sequencer (
    input  logic   clk,
    input  logic   rst_n,
    rts_req_if.sink   req,
    rts_rsp_if.source rsp
);
    import rts_pkg::*;

    req_word_t          item_reg;
    logic               item_valid_reg, item_valid_next;
    rsp_word_t          res_reg;
    logic               res_valid_reg, res_valid_next;
    rsp_word_t          step_res;
    logic [PHASE_W-1:0] core_phase;
    logic               advance;

    // Move the held word into the sequencer when the output slot is free or is being read
    assign advance   = item_valid_reg && (!res_valid_reg || rsp.ready);
    assign req.ready = !item_valid_reg || advance;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (req.valid && req.ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers: the input captures on accept, the output on advance; each holds otherwise
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.action      <= req.action;
            item_reg.dev_address <= req.dev_address;
            item_reg.reg_address <= req.reg_address;
            item_reg.byte_count  <= req.byte_count;
            item_reg.target_nack <= req.target_nack;
            item_reg.rx_data     <= req.rx_data;
            item_reg.write_byte  <= req.write_byte;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    rts_seq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .result  (step_res),
        .phase   (core_phase)
    );

    assign rsp.valid      = res_valid_reg;
    assign rsp.bus_op     = res_reg.bus_op;
    assign rsp.tx_byte    = res_reg.tx_byte;
    assign rsp.ack_level  = res_reg.ack_level;
    assign rsp.read_data  = res_reg.read_data;
    assign rsp.read_valid = res_reg.read_valid;
    assign rsp.want_byte  = res_reg.want_byte;
    assign rsp.finished   = res_reg.finished;
    assign rsp.succeeded  = res_reg.succeeded;
    assign rsp.refused    = res_reg.refused;

    // A held word with a free output slot must reach the output next cycle
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !res_valid_reg) |=> res_valid_reg)
        else $error("held word did not advance into free output slot");

    // A finished report returns the sequencer to idle
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.finished) |=> (core_phase == PH_IDLE))
        else $error("sequencer not idle after finished report");

    // A byte request leaves the sequencer waiting for the host byte
    a_want_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.want_byte) |=> (core_phase == PH_WANT))
        else $error("sequencer not waiting after byte request");

endmodule
